>>> rtl/assert_macros.svh
// Concurrent assertion helpers, sampled on the rising clock edge, off in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// hold a condition at every edge
`define ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("assertion failed");

// antecedent implies consequent sequence
`define ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> cons) \
      else $error("assertion failed");

`endif

>>> rtl/rpi_pkg.sv
package rpi_pkg;

   localparam int FIELD_BITS = 32;
   localparam int LEN_BITS   = 31;

   typedef struct packed {
      logic signed [FIELD_BITS-1:0] normal_x;
      logic signed [FIELD_BITS-1:0] normal_y;
      logic signed [FIELD_BITS-1:0] normal_z;
      logic signed [FIELD_BITS-1:0] plane_offset;
      logic signed [FIELD_BITS-1:0] origin_x;
      logic signed [FIELD_BITS-1:0] origin_y;
      logic signed [FIELD_BITS-1:0] origin_z;
      logic signed [FIELD_BITS-1:0] dir_x;
      logic signed [FIELD_BITS-1:0] dir_y;
      logic signed [FIELD_BITS-1:0] dir_z;
      logic        [LEN_BITS-1:0]   max_length;
   } req_type;

   typedef struct packed {
      logic                         hit;
      logic signed [FIELD_BITS-1:0] hit_distance;
      logic signed [FIELD_BITS-1:0] hit_x;
      logic signed [FIELD_BITS-1:0] hit_y;
      logic signed [FIELD_BITS-1:0] hit_z;
   } rsp_type;

endpackage

>>> rtl/ray_plane_intersection_unit.sv
// Ray/plane intersection, one independent test per item. An item is taken at any edge
// with start high; busy stays low because the pipeline never stalls. Each result
// leaves on rsp_valid for one cycle, one item per cycle sustained. Between the dot
// products and the hit point multiply sits the restoring divider, one quotient bit
// per stage. The receiver cannot stall, so it must take every result.
`include "assert_macros.svh"

module ray_plane_intersection_unit #(
   parameter int FRAC_BITS = 16,
   parameter int WORD_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  rpi_pkg::req_type req_item,
   output logic             busy,
   output logic             rsp_valid,
   output rpi_pkg::rsp_type rsp_item
);

   localparam int W    = WORD_BITS;
   localparam int F    = FRAC_BITS;
   localparam int PW   = 2 * W;
   localparam int NW   = PW + 2;
   localparam int QW   = NW + F;
   localparam int LB   = rpi_pkg::LEN_BITS;
   localparam int FB   = rpi_pkg::FIELD_BITS;
   localparam int SW   = 2 + LB + 6 * W;
   localparam int LAT  = QW + 7;

   function automatic logic signed [W-1:0] to_word(logic [FB-1:0] f);
      logic [63:0] z;
      z = {32'd0, f};
      return z[W-1:0];
   endfunction

   function automatic logic [FB-1:0] to_field(logic signed [W-1:0] v);
      logic signed [63:0] z;
      z = 64'(v);
      return z[FB-1:0];
   endfunction

   logic req_accept;
   assign busy       = 1'b0;
   assign req_accept = start && !busy;

   // stage 1: capture
   logic                v1_ff;
   logic signed [W-1:0] n1_ff [3];
   logic signed [W-1:0] o1_ff [3];
   logic signed [W-1:0] d1_ff [3];
   logic signed [W-1:0] off1_ff;
   logic [LB-1:0]       len1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= req_accept;
      end
      n1_ff[0] <= to_word(req_item.normal_x);
      n1_ff[1] <= to_word(req_item.normal_y);
      n1_ff[2] <= to_word(req_item.normal_z);
      o1_ff[0] <= to_word(req_item.origin_x);
      o1_ff[1] <= to_word(req_item.origin_y);
      o1_ff[2] <= to_word(req_item.origin_z);
      d1_ff[0] <= to_word(req_item.dir_x);
      d1_ff[1] <= to_word(req_item.dir_y);
      d1_ff[2] <= to_word(req_item.dir_z);
      off1_ff  <= to_word(req_item.plane_offset);
      len1_ff  <= req_item.max_length;
   end

   // stage 2: products
   logic                 v2_ff;
   logic signed [PW-1:0] nd2_ff [3];
   logic signed [PW-1:0] no2_ff [3];
   logic signed [W-1:0]  o2_ff  [3];
   logic signed [W-1:0]  d2_ff  [3];
   logic signed [W-1:0]  off2_ff;
   logic [LB-1:0]        len2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      for (int i = 0; i < 3; i++) begin
         nd2_ff[i] <= PW'(n1_ff[i]) * PW'(d1_ff[i]);
         no2_ff[i] <= PW'(n1_ff[i]) * PW'(o1_ff[i]);
         o2_ff[i]  <= o1_ff[i];
         d2_ff[i]  <= d1_ff[i];
      end
      off2_ff <= off1_ff;
      len2_ff <= len1_ff;
   end

   // stage 3: sums
   logic                 v3_ff;
   logic signed [NW-1:0] dot3_ff;
   logic signed [NW-1:0] num3_ff;
   logic signed [W-1:0]  o3_ff [3];
   logic signed [W-1:0]  d3_ff [3];
   logic [LB-1:0]        len3_ff;
   logic signed [NW-1:0] dot3_in;
   logic signed [NW-1:0] num3_in;

   always_comb begin
      dot3_in = NW'(nd2_ff[0]) + NW'(nd2_ff[1]) + NW'(nd2_ff[2]);
      num3_in = (NW'(off2_ff) <<< F) + NW'(no2_ff[0]) + NW'(no2_ff[1]) + NW'(no2_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      dot3_ff <= dot3_in;
      num3_ff <= num3_in;
      o3_ff   <= o2_ff;
      d3_ff   <= d2_ff;
      len3_ff <= len2_ff;
   end

   // stage 4: magnitudes for the divider
   logic                 v4_ff;
   logic [QW-1:0]        mag4_ff;
   logic [NW-1:0]        den4_ff;
   logic [SW-1:0]        side4_ff;
   logic signed [QW-1:0] numsh4;
   logic                 neg4;
   logic [QW-1:0]        mag4_in;

   always_comb begin
      numsh4  = QW'(num3_ff) <<< F;
      neg4    = numsh4[QW-1];
      mag4_in = neg4 ? QW'(-numsh4) : QW'(numsh4);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      mag4_ff  <= mag4_in;
      den4_ff  <= NW'(-dot3_ff);
      side4_ff <= {dot3_ff[NW-1], neg4, len3_ff,
                   o3_ff[0], o3_ff[1], o3_ff[2], d3_ff[0], d3_ff[1], d3_ff[2]};
   end

   logic          vq;
   logic [QW-1:0] quot;
   logic [SW-1:0] sideq;

   rpi_divider #(
      .QUOT_BITS(QW),
      .DEN_BITS (NW),
      .SIDE_BITS(SW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v4_ff),
      .in_num   (mag4_ff),
      .in_den   (den4_ff),
      .in_side  (side4_ff),
      .out_valid(vq),
      .out_quot (quot),
      .out_side (sideq)
   );

   // stage 5: sign, length test, saturate
   logic                  facing_q;
   logic                  neg_q;
   logic [LB-1:0]         len_q;
   logic signed [W-1:0]   oq [3];
   logic signed [W-1:0]   dq [3];
   logic signed [QW:0]    qs;
   logic signed [QW:0]    lenx;
   logic signed [QW:0]    wmax;
   logic signed [QW:0]    wmin;
   logic                  hit5_in;
   logic signed [W-1:0]   t5_in;

   always_comb begin
      {facing_q, neg_q, len_q, oq[0], oq[1], oq[2], dq[0], dq[1], dq[2]} = sideq;
      qs      = neg_q ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
      lenx    = $signed((QW+1)'(len_q));
      wmax    = $signed((QW+1)'({1'b0, {(W-1){1'b1}}}));
      wmin    = -wmax - 1;
      hit5_in = facing_q && (qs < lenx);
      priority if (qs > wmax) begin
         t5_in = wmax[W-1:0];
      end else if (qs < wmin) begin
         t5_in = wmin[W-1:0];
      end else begin
         t5_in = qs[W-1:0];
      end
   end

   logic                v5_ff;
   logic                hit5_ff;
   logic signed [W-1:0] t5_ff;
   logic signed [W-1:0] o5_ff [3];
   logic signed [W-1:0] d5_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= vq;
      end
      hit5_ff <= hit5_in;
      t5_ff   <= t5_in;
      o5_ff   <= oq;
      d5_ff   <= dq;
   end

   // stage 6: direction times distance
   logic                 v6_ff;
   logic                 hit6_ff;
   logic signed [W-1:0]  t6_ff;
   logic signed [W-1:0]  o6_ff [3];
   logic signed [PW-1:0] p6_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else begin
         v6_ff <= v5_ff;
      end
      hit6_ff <= hit5_ff;
      t6_ff   <= t5_ff;
      o6_ff   <= o5_ff;
      for (int i = 0; i < 3; i++) begin
         p6_ff[i] <= PW'(d5_ff[i]) * PW'(t5_ff);
      end
   end

   // stage 7: add origin, saturate, drop misses
   logic signed [PW:0]  sum7  [3];
   logic signed [W-1:0] pt7   [3];
   logic signed [PW:0]  smax;
   logic signed [PW:0]  smin;
   rpi_pkg::rsp_type    rsp_in;

   always_comb begin
      smax = $signed((PW+1)'({1'b0, {(W-1){1'b1}}}));
      smin = -smax - 1;
      for (int i = 0; i < 3; i++) begin
         sum7[i] = (PW+1)'(o6_ff[i]) + (PW+1)'(p6_ff[i] >>> F);
         priority if (sum7[i] > smax) begin
            pt7[i] = smax[W-1:0];
         end else if (sum7[i] < smin) begin
            pt7[i] = smin[W-1:0];
         end else begin
            pt7[i] = sum7[i][W-1:0];
         end
      end
      rsp_in = '0;
      if (hit6_ff) begin
         rsp_in.hit          = 1'b1;
         rsp_in.hit_distance = to_field(t6_ff);
         rsp_in.hit_x        = to_field(pt7[0]);
         rsp_in.hit_y        = to_field(pt7[1]);
         rsp_in.hit_z        = to_field(pt7[2]);
      end
   end

   logic             rsp_valid_ff;
   rpi_pkg::rsp_type rsp_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= v6_ff;
      end
      rsp_item_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   `ASSERT_ALWAYS(a_never_busy, !busy)
   `ASSERT_IMPLIES(a_latency, req_accept, ##LAT rsp_valid)
   `ASSERT_IMPLIES(a_miss_zero, rsp_valid && !rsp_item.hit,
                   (rsp_item.hit_distance == '0 && rsp_item.hit_x == '0 &&
                    rsp_item.hit_y == '0 && rsp_item.hit_z == '0))

endmodule

>>> rtl/rpi_divider.sv
`include "assert_macros.svh"

module rpi_divider #(
   parameter int QUOT_BITS = 82,
   parameter int DEN_BITS  = 66,
   parameter int SIDE_BITS = 225
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [QUOT_BITS-1:0] in_num,
   input  logic [DEN_BITS-1:0]  in_den,
   input  logic [SIDE_BITS-1:0] in_side,
   output logic                 out_valid,
   output logic [QUOT_BITS-1:0] out_quot,
   output logic [SIDE_BITS-1:0] out_side
);

   logic                 valid_ff [QUOT_BITS];
   logic [DEN_BITS-1:0]  rem_ff   [QUOT_BITS];
   logic [DEN_BITS-1:0]  den_ff   [QUOT_BITS];
   logic [QUOT_BITS-1:0] num_ff   [QUOT_BITS];
   logic [QUOT_BITS-1:0] quot_ff  [QUOT_BITS];
   logic [SIDE_BITS-1:0] side_ff  [QUOT_BITS];

   for (genvar s = 0; s < QUOT_BITS; s++) begin : g_stage
      logic                 valid_prev;
      logic [DEN_BITS-1:0]  rem_prev;
      logic [DEN_BITS-1:0]  den_prev;
      logic [QUOT_BITS-1:0] num_prev;
      logic [QUOT_BITS-1:0] quot_prev;
      logic [SIDE_BITS-1:0] side_prev;
      logic [DEN_BITS:0]    trial;
      logic                 take;
      logic [DEN_BITS:0]    diff;
      logic [DEN_BITS-1:0]  rem_in;
      logic [QUOT_BITS-1:0] quot_in;

      if (s == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rem_prev   = '0;
         assign den_prev   = in_den;
         assign num_prev   = in_num;
         assign quot_prev  = '0;
         assign side_prev  = in_side;
      end else begin : g_next
         assign valid_prev = valid_ff[s-1];
         assign rem_prev   = rem_ff[s-1];
         assign den_prev   = den_ff[s-1];
         assign num_prev   = num_ff[s-1];
         assign quot_prev  = quot_ff[s-1];
         assign side_prev  = side_ff[s-1];
      end

      always_comb begin
         trial   = {rem_prev, num_prev[QUOT_BITS-1]};
         take    = (trial >= {1'b0, den_prev});
         diff    = trial - {1'b0, den_prev};
         rem_in  = take ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
         quot_in = {quot_prev[QUOT_BITS-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= valid_prev;
         end
         rem_ff[s]  <= rem_in;
         den_ff[s]  <= den_prev;
         num_ff[s]  <= {num_prev[QUOT_BITS-2:0], 1'b0};
         quot_ff[s] <= quot_in;
         side_ff[s] <= side_prev;
      end
   end

   assign out_valid = valid_ff[QUOT_BITS-1];
   assign out_quot  = quot_ff[QUOT_BITS-1];
   assign out_side  = side_ff[QUOT_BITS-1];

   `ASSERT_IMPLIES(a_rem_below_den, out_valid && den_ff[QUOT_BITS-1] != '0,
                   (rem_ff[QUOT_BITS-1] < den_ff[QUOT_BITS-1]))
   `ASSERT_IMPLIES(a_valid_advances, in_valid, ##1 valid_ff[0])
   `ASSERT_IMPLIES(a_valid_reaches_out, in_valid, ##QUOT_BITS out_valid)

endmodule
